FILE: src/rc6_pkg.sv
// rc6_pkg: sizes, codes, state encoding and round helpers for the RC6-32/20 engine.
// Used by rc6_block_cipher_unit; no dependencies of its own.
package rc6_pkg;

  // Cipher sizing
  localparam int ROUNDS        = 20;
  localparam int MAX_KEY_BYTES = 32;
  localparam int RK_NUM        = 2 * ROUNDS + 4;
  localparam int RK_AW         = $clog2(RK_NUM);
  localparam int KW_NUM        = (MAX_KEY_BYTES + 3) / 4;
  localparam int KW_AW         = (KW_NUM > 1) ? $clog2(KW_NUM) : 1;
  localparam int KWC_W         = $clog2(KW_NUM + 1);
  localparam int CNT_W         = $clog2(MAX_KEY_BYTES + 1);
  localparam int RND_W         = $clog2(ROUNDS + 1);
  localparam int PASS_MAX      = 3 * ((KW_NUM > RK_NUM) ? KW_NUM : RK_NUM);
  localparam int PASS_W        = $clog2(PASS_MAX + 1);

  // Key schedule magic constants
  localparam logic [31:0] P32 = 32'hB7E1_5163;
  localparam logic [31:0] Q32 = 32'h9E37_79B9;

  // Operation codes on the input beat
  typedef enum logic [1:0] {
    OP_KEY = 2'd0,
    OP_ENC = 2'd1,
    OP_DEC = 2'd2
  } op_e;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_KINIT, ST_KRD, ST_KA, ST_KB, ST_KEND,
    ST_EW0, ST_EW1, ST_EM1, ST_EM2, ST_EUA, ST_EUC, ST_EF0, ST_EF1, ST_EF2,
    ST_DW0, ST_DW1, ST_DM1, ST_DM2, ST_DUC, ST_DUA, ST_DF0, ST_DF1, ST_DF2,
    ST_DONE
  } state_e;

  // 32-bit rotate left
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  // Quadratic mixing: rotl(x * (2x + 1), 5)
  function automatic logic [31:0] mix32(input logic [31:0] x);
    logic [31:0] p;
    p = x * {x[30:0], 1'b1};
    return rotl32(p, 5'd5);
  endfunction

endpackage

FILE: src/rc6_ram.sv
// rc6_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rc6_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 44,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rc6_block_cipher_unit.sv
// RC6-32/20 block cipher engine: key loading, key expansion, encrypt and decrypt.
// Depends on rc6_pkg and rc6_ram (round-key store).
//
// One beat at a time. Key bytes come with op 0; the byte marked last starts
// key expansion, which holds off input while it writes the 44-entry initial
// table, reads its first entry, runs 132 mixing steps and finishes. An
// encrypt or decrypt beat runs whitening at the start, the rounds and
// whitening at the end, then yields one result in the output register once
// that register is free. Each round steps through EM1, EM2, EUA and EUC (DM1,
// DM2, DUC and DUA to decrypt) in turn, as the single shared multiplier forms
// the two mix products of a round one after the other and the round-key RAM
// has one read port. Without an expanded key a block beat returns zero words
// with no_key set once the output register is free. Input is taken when the
// sequencer is idle, also while a finished result still waits on the output.
module rc6_block_cipher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  key_byte_i,
  input  logic        key_last_i,
  input  logic [31:0] word_a_i,
  input  logic [31:0] word_b_i,
  input  logic [31:0] word_c_i,
  input  logic [31:0] word_d_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_a_o,
  output logic [31:0] out_b_o,
  output logic [31:0] out_c_o,
  output logic [31:0] out_d_o,
  output logic        no_key_o
);

  rc6_pkg::state_e state_q, state_d;

  // Control state
  logic [31:0]               kw_q [rc6_pkg::KW_NUM];
  logic [rc6_pkg::CNT_W-1:0] key_count_q;
  logic                      key_valid_q;
  logic                      out_valid_q;

  // Datapath registers
  logic [31:0]                a_q, b_q, c_q, d_q, t_q, u_q;
  logic                       nokey_q;
  logic [rc6_pkg::RND_W-1:0]  rnd_q;
  logic [rc6_pkg::RK_AW-1:0]  i_q;
  logic [rc6_pkg::KW_AW-1:0]  j_q;
  logic [rc6_pkg::PASS_W-1:0] pass_q;
  logic [31:0]                out_a_q, out_b_q, out_c_q, out_d_q;
  logic                       out_nokey_q;

  // RAM port
  logic                      ram_we;
  logic [rc6_pkg::RK_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]               ram_wdata, ram_rdata;

  // Shared units and helpers
  logic [31:0]                mul_in, mix_y, rot_x, rot_y, ab_sum;
  logic [4:0]                 rot_n;
  logic                       in_fire, out_load;
  logic [rc6_pkg::CNT_W:0]    kw_round;
  logic [rc6_pkg::KWC_W-1:0]  kw_cnt;
  logic [rc6_pkg::PASS_W-1:0] pass_base, pass_total;
  logic [rc6_pkg::RK_AW-1:0]  i_next, rk_even, rk_odd;
  logic                       i_wrap, j_wrap, pass_end;

  rc6_ram #(
    .WIDTH(32),
    .DEPTH(rc6_pkg::RK_NUM)
  ) u_rk_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign in_ready_o = (state_q == rc6_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (state_q == rc6_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  // Key word count c = max(1, ceil(bytes / 4)) and mixing step total
  assign kw_round   = ((rc6_pkg::CNT_W+1)'(key_count_q) + (rc6_pkg::CNT_W+1)'(3)) >> 2;
  assign kw_cnt     = (kw_round == '0) ? rc6_pkg::KWC_W'(1) : rc6_pkg::KWC_W'(kw_round);
  assign pass_base  = (rc6_pkg::PASS_W'(kw_cnt) > rc6_pkg::PASS_W'(rc6_pkg::RK_NUM)) ?
                      rc6_pkg::PASS_W'(kw_cnt) : rc6_pkg::PASS_W'(rc6_pkg::RK_NUM);
  assign pass_total = (pass_base << 1) + pass_base;
  assign pass_end   = (pass_q == pass_total - rc6_pkg::PASS_W'(1));

  // Index stepping
  assign i_wrap  = (i_q == rc6_pkg::RK_AW'(rc6_pkg::RK_NUM - 1));
  assign i_next  = i_wrap ? '0 : i_q + rc6_pkg::RK_AW'(1);
  assign j_wrap  = (rc6_pkg::KWC_W'(j_q) == kw_cnt - rc6_pkg::KWC_W'(1));
  assign rk_even = rc6_pkg::RK_AW'({rnd_q, 1'b0});
  assign rk_odd  = rc6_pkg::RK_AW'({rnd_q, 1'b1});

  // Shared multiplier for the quadratic mix
  assign mul_in = ((state_q == rc6_pkg::ST_EM1) || (state_q == rc6_pkg::ST_DM1)) ? b_q : d_q;
  assign mix_y  = rc6_pkg::mix32(mul_in);

  // Shared rotator
  assign ab_sum = a_q + b_q;
  always_comb begin
    rot_x = '0;
    rot_n = '0;
    case (state_q)
      rc6_pkg::ST_KA: begin
        rot_x = ram_rdata + ab_sum;
        rot_n = 5'd3;
      end
      rc6_pkg::ST_KB: begin
        rot_x = kw_q[j_q] + ab_sum;
        rot_n = ab_sum[4:0];
      end
      rc6_pkg::ST_EUA: begin
        rot_x = a_q ^ t_q;
        rot_n = u_q[4:0];
      end
      rc6_pkg::ST_EUC: begin
        rot_x = c_q ^ u_q;
        rot_n = t_q[4:0];
      end
      rc6_pkg::ST_DUC: begin
        rot_x = c_q - ram_rdata;
        rot_n = 5'd0 - t_q[4:0];
      end
      rc6_pkg::ST_DUA: begin
        rot_x = a_q - ram_rdata;
        rot_n = 5'd0 - u_q[4:0];
      end
      default: begin
        rot_x = '0;
        rot_n = '0;
      end
    endcase
  end
  assign rot_y = rc6_pkg::rotl32(rot_x, rot_n);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rc6_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (op_i)
            rc6_pkg::OP_KEY: state_d = key_last_i ? rc6_pkg::ST_KINIT : rc6_pkg::ST_IDLE;
            rc6_pkg::OP_ENC: state_d = key_valid_q ? rc6_pkg::ST_EW0 : rc6_pkg::ST_DONE;
            rc6_pkg::OP_DEC: state_d = key_valid_q ? rc6_pkg::ST_DW0 : rc6_pkg::ST_DONE;
            default:         state_d = rc6_pkg::ST_IDLE;
          endcase
        end
      end
      rc6_pkg::ST_KINIT: state_d = i_wrap ? rc6_pkg::ST_KRD : rc6_pkg::ST_KINIT;
      rc6_pkg::ST_KRD:   state_d = rc6_pkg::ST_KA;
      rc6_pkg::ST_KA:    state_d = rc6_pkg::ST_KB;
      rc6_pkg::ST_KB:    state_d = pass_end ? rc6_pkg::ST_KEND : rc6_pkg::ST_KA;
      rc6_pkg::ST_KEND:  state_d = rc6_pkg::ST_IDLE;
      rc6_pkg::ST_EW0:   state_d = rc6_pkg::ST_EW1;
      rc6_pkg::ST_EW1:   state_d = rc6_pkg::ST_EM1;
      rc6_pkg::ST_EM1:   state_d = rc6_pkg::ST_EM2;
      rc6_pkg::ST_EM2:   state_d = rc6_pkg::ST_EUA;
      rc6_pkg::ST_EUA:   state_d = rc6_pkg::ST_EUC;
      rc6_pkg::ST_EUC: begin
        state_d = (rnd_q == rc6_pkg::RND_W'(rc6_pkg::ROUNDS)) ?
                  rc6_pkg::ST_EF0 : rc6_pkg::ST_EM1;
      end
      rc6_pkg::ST_EF0:   state_d = rc6_pkg::ST_EF1;
      rc6_pkg::ST_EF1:   state_d = rc6_pkg::ST_EF2;
      rc6_pkg::ST_EF2:   state_d = rc6_pkg::ST_DONE;
      rc6_pkg::ST_DW0:   state_d = rc6_pkg::ST_DW1;
      rc6_pkg::ST_DW1:   state_d = rc6_pkg::ST_DM1;
      rc6_pkg::ST_DM1:   state_d = rc6_pkg::ST_DM2;
      rc6_pkg::ST_DM2:   state_d = rc6_pkg::ST_DUC;
      rc6_pkg::ST_DUC:   state_d = rc6_pkg::ST_DUA;
      rc6_pkg::ST_DUA: begin
        state_d = (rnd_q == rc6_pkg::RND_W'(1)) ? rc6_pkg::ST_DF0 : rc6_pkg::ST_DM1;
      end
      rc6_pkg::ST_DF0:   state_d = rc6_pkg::ST_DF1;
      rc6_pkg::ST_DF1:   state_d = rc6_pkg::ST_DF2;
      rc6_pkg::ST_DF2:   state_d = rc6_pkg::ST_DONE;
      rc6_pkg::ST_DONE:  state_d = out_load ? rc6_pkg::ST_IDLE : rc6_pkg::ST_DONE;
      default:           state_d = rc6_pkg::ST_IDLE;
    endcase
  end

  // RAM control: each read is issued in the state before the one that uses its data
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = i_q;
    ram_wdata = a_q;
    ram_raddr = '0;
    case (state_q)
      rc6_pkg::ST_IDLE: begin
        ram_raddr = (op_i == rc6_pkg::OP_DEC) ? rc6_pkg::RK_AW'(rc6_pkg::RK_NUM - 1) : '0;
      end
      rc6_pkg::ST_KINIT: ram_we = 1'b1;
      rc6_pkg::ST_KRD:   ram_raddr = i_q;
      rc6_pkg::ST_KA: begin
        ram_we    = 1'b1;
        ram_wdata = rot_y;
      end
      rc6_pkg::ST_KB:    ram_raddr = i_next;
      rc6_pkg::ST_EW0:   ram_raddr = rc6_pkg::RK_AW'(1);
      rc6_pkg::ST_EM2:   ram_raddr = rk_even;
      rc6_pkg::ST_EUA:   ram_raddr = rk_odd;
      rc6_pkg::ST_EF0:   ram_raddr = rc6_pkg::RK_AW'(rc6_pkg::RK_NUM - 2);
      rc6_pkg::ST_EF1:   ram_raddr = rc6_pkg::RK_AW'(rc6_pkg::RK_NUM - 1);
      rc6_pkg::ST_DW0:   ram_raddr = rc6_pkg::RK_AW'(rc6_pkg::RK_NUM - 2);
      rc6_pkg::ST_DM2:   ram_raddr = rk_odd;
      rc6_pkg::ST_DUC:   ram_raddr = rk_even;
      rc6_pkg::ST_DF0:   ram_raddr = rc6_pkg::RK_AW'(1);
      default:           ram_raddr = '0;
    endcase
  end

  // Control registers: state, key store, key status, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rc6_pkg::ST_IDLE;
      key_count_q <= '0;
      key_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < rc6_pkg::KW_NUM; k++) begin
        kw_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_fire && (op_i == rc6_pkg::OP_KEY) &&
          (key_count_q < rc6_pkg::CNT_W'(rc6_pkg::MAX_KEY_BYTES))) begin
        kw_q[key_count_q[rc6_pkg::KW_AW+1:2]] <= kw_q[key_count_q[rc6_pkg::KW_AW+1:2]] |
            (32'(key_byte_i) << {key_count_q[1:0], 3'b000});
        key_count_q <= key_count_q + rc6_pkg::CNT_W'(1);
      end
      if (state_q == rc6_pkg::ST_KB) begin
        kw_q[j_q] <= rot_y;
      end
      if (state_q == rc6_pkg::ST_KEND) begin
        for (int k = 0; k < rc6_pkg::KW_NUM; k++) begin
          kw_q[k] <= '0;
        end
        key_count_q <= '0;
        key_valid_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      rc6_pkg::ST_IDLE: begin
        if (in_fire && (op_i == rc6_pkg::OP_KEY)) begin
          a_q <= rc6_pkg::P32;
          i_q <= '0;
        end else begin
          a_q <= key_valid_q ? word_a_i : '0;
        end
        b_q     <= key_valid_q ? word_b_i : '0;
        c_q     <= key_valid_q ? word_c_i : '0;
        d_q     <= key_valid_q ? word_d_i : '0;
        nokey_q <= !key_valid_q;
      end
      // initial table: P + s*Q
      rc6_pkg::ST_KINIT: begin
        i_q <= i_next;
        if (i_wrap) begin
          a_q    <= '0;
          b_q    <= '0;
          j_q    <= '0;
          pass_q <= '0;
        end else begin
          a_q <= a_q + rc6_pkg::Q32;
        end
      end
      rc6_pkg::ST_KA: a_q <= rot_y;
      rc6_pkg::ST_KB: begin
        b_q    <= rot_y;
        i_q    <= i_next;
        j_q    <= j_wrap ? '0 : j_q + rc6_pkg::KW_AW'(1);
        pass_q <= pass_q + rc6_pkg::PASS_W'(1);
      end
      // encrypt
      rc6_pkg::ST_EW0: b_q <= b_q + ram_rdata;
      rc6_pkg::ST_EW1: begin
        d_q   <= d_q + ram_rdata;
        rnd_q <= rc6_pkg::RND_W'(1);
      end
      rc6_pkg::ST_EM1, rc6_pkg::ST_DM1: t_q <= mix_y;
      rc6_pkg::ST_EM2, rc6_pkg::ST_DM2: u_q <= mix_y;
      rc6_pkg::ST_EUA: a_q <= rot_y + ram_rdata;
      rc6_pkg::ST_EUC: begin
        a_q   <= b_q;
        b_q   <= rot_y + ram_rdata;
        c_q   <= d_q;
        d_q   <= a_q;
        rnd_q <= rnd_q + rc6_pkg::RND_W'(1);
      end
      rc6_pkg::ST_EF1: a_q <= a_q + ram_rdata;
      rc6_pkg::ST_EF2: c_q <= c_q + ram_rdata;
      // decrypt; the word rotation opening each round is folded into the
      // previous step
      rc6_pkg::ST_DW0: c_q <= c_q - ram_rdata;
      rc6_pkg::ST_DW1: begin
        a_q   <= d_q;
        b_q   <= a_q - ram_rdata;
        c_q   <= b_q;
        d_q   <= c_q;
        rnd_q <= rc6_pkg::RND_W'(rc6_pkg::ROUNDS);
      end
      rc6_pkg::ST_DUC: c_q <= rot_y ^ u_q;
      rc6_pkg::ST_DUA: begin
        if (rnd_q == rc6_pkg::RND_W'(1)) begin
          a_q <= rot_y ^ t_q;
        end else begin
          a_q <= d_q;
          b_q <= rot_y ^ t_q;
          c_q <= b_q;
          d_q <= c_q;
        end
        rnd_q <= rnd_q - rc6_pkg::RND_W'(1);
      end
      rc6_pkg::ST_DF1: d_q <= d_q - ram_rdata;
      rc6_pkg::ST_DF2: b_q <= b_q - ram_rdata;
      default: begin
      end
    endcase
    // output register
    if (out_load) begin
      out_a_q     <= a_q;
      out_b_q     <= b_q;
      out_c_q     <= c_q;
      out_d_q     <= d_q;
      out_nokey_q <= nokey_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_a_o     = out_a_q;
  assign out_b_o     = out_b_q;
  assign out_c_o     = out_c_q;
  assign out_d_o     = out_d_q;
  assign no_key_o    = out_nokey_q;

endmodule
